[rtl/core/arsl_pkg.sv]
// ----------------------------------------------------------------------------
// arsl_pkg
// Shared types and codes for the address range symbol lookup block.
// ----------------------------------------------------------------------------
package arsl_pkg;

  // request command codes
  typedef enum logic [1:0] {
    CMD_INSERT_FUNC = 2'd0,
    CMD_INSERT_VAR  = 2'd1,
    CMD_LOOKUP_FUNC = 2'd2,
    CMD_LOOKUP_VAR  = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int OUT_W    = 8;

endpackage

[rtl/core/address_range_symbol_lookup.sv]
// ----------------------------------------------------------------------------
// address_range_symbol_lookup
// Two region tables (functions, variables) held in synchronous memories,
// with append inserts and a first-match linear scan for lookups.
// ----------------------------------------------------------------------------
// One request is handled at a time. An insert goes from acceptance through
// the emit state before the next acceptance. A lookup reads one table entry
// per cycle from the region memory (the read is registered) and stops at the
// first match or after the last valid entry; a lookup on an empty table goes
// straight to the emit state. The scan of the memory is what sets the lookup
// time. A finished result waits in the output register while the next
// request is accepted. Entry numbers are reported modulo 64 in the 6-bit
// index field.
module address_range_symbol_lookup #(
  parameter int TABLE_DEPTH = 64,
  parameter int ADDR_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst,
  // request stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd [1:0], addr, size, zero padding to whole bytes
  input  logic [((2*ADDR_WIDTH+arsl_pkg::CMD_W+7)/8)*8-1:0] s_axis_tdata,
  // result stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status [1:0], index [7:2]
  output logic [arsl_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 2 * ADDR_WIDTH;

  // request fields
  arsl_pkg::cmd_t          req_cmd;
  logic [ADDR_WIDTH-1:0]   req_addr;
  logic [ADDR_WIDTH-1:0]   req_size;

  assign req_cmd  = arsl_pkg::cmd_t'(s_axis_tdata[arsl_pkg::CMD_W-1:0]);
  assign req_addr = s_axis_tdata[arsl_pkg::CMD_W +: ADDR_WIDTH];
  assign req_size = s_axis_tdata[arsl_pkg::CMD_W+ADDR_WIDTH +: ADDR_WIDTH];

  // state
  arsl_pkg::state_t        state;
  arsl_pkg::state_t        state_next;
  logic [CNT_W-1:0]        func_count;
  logic [CNT_W-1:0]        var_count;
  logic [IDX_W-1:0]        scan_ptr;
  logic                    scan_var;
  logic [ADDR_WIDTH-1:0]   scan_addr;
  logic [ADDR_WIDTH-1:0]   scan_size;
  arsl_pkg::status_t       res_status;
  logic [arsl_pkg::INDEX_W-1:0] res_index;

  // region memories, base in the low half, length in the high half
  logic [ENTRY_W-1:0]      func_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]      var_mem  [TABLE_DEPTH];
  logic [ENTRY_W-1:0]      func_rd;
  logic [ENTRY_W-1:0]      var_rd;

  // control
  logic                    req_accept;
  logic                    req_lookup;
  logic                    req_is_var;
  logic [CNT_W-1:0]        req_count;
  logic                    req_full;
  logic                    req_empty;
  logic                    out_free;
  logic [IDX_W-1:0]        ptr_inc;
  logic [IDX_W-1:0]        rd_addr;
  logic [CNT_W-1:0]        sel_count;
  logic                    scan_last;
  logic                    scan_hit;
  logic                    wr_func;
  logic                    wr_var;
  logic [ENTRY_W-1:0]      sel_entry;
  logic [ADDR_WIDTH-1:0]   ent_base;
  logic [ADDR_WIDTH-1:0]   ent_len;
  logic [ADDR_WIDTH-1:0]   rel_addr;
  logic [CNT_W+arsl_pkg::INDEX_W-1:0] cnt_wide;
  logic [IDX_W+arsl_pkg::INDEX_W-1:0] ptr_wide;

  // request decode
  assign req_accept = s_axis_tvalid && s_axis_tready;
  assign req_lookup = (req_cmd == arsl_pkg::CMD_LOOKUP_FUNC) ||
                      (req_cmd == arsl_pkg::CMD_LOOKUP_VAR);
  assign req_is_var = (req_cmd == arsl_pkg::CMD_INSERT_VAR) ||
                      (req_cmd == arsl_pkg::CMD_LOOKUP_VAR);
  assign req_count  = req_is_var ? var_count : func_count;
  assign req_full   = (req_count == CNT_W'(TABLE_DEPTH));
  assign req_empty  = (req_count == '0);
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign cnt_wide   = {{arsl_pkg::INDEX_W{1'b0}}, req_count};
  assign ptr_wide   = {{arsl_pkg::INDEX_W{1'b0}}, scan_ptr};

  // scan compare on the entry read in the previous cycle
  assign ptr_inc   = scan_ptr + 1'b1;
  assign sel_count = scan_var ? var_count : func_count;
  assign scan_last = ((CNT_W'(scan_ptr) + CNT_W'(1)) == sel_count);
  assign sel_entry = scan_var ? var_rd : func_rd;
  assign ent_base  = sel_entry[ADDR_WIDTH-1:0];
  assign ent_len   = sel_entry[ENTRY_W-1:ADDR_WIDTH];
  assign rel_addr  = scan_addr - ent_base;

  always_comb begin
    if (scan_addr < ent_base) begin
      scan_hit = 1'b0;
    end else if (scan_var) begin
      scan_hit = (scan_size <= ent_len) && (rel_addr <= (ent_len - scan_size));
    end else begin
      scan_hit = (rel_addr < ent_len);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      arsl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (req_lookup && !req_empty) ? arsl_pkg::ST_SCAN : arsl_pkg::ST_EMIT;
        end
      end
      arsl_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = arsl_pkg::ST_EMIT;
        end
      end
      arsl_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = arsl_pkg::ST_IDLE;
        end
      end
      default: state_next = arsl_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    rd_addr       = ptr_inc;
    wr_func       = 1'b0;
    wr_var        = 1'b0;
    unique case (state)
      arsl_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_addr       = '0;
        wr_func       = s_axis_tvalid && (req_cmd == arsl_pkg::CMD_INSERT_FUNC) && !req_full;
        wr_var        = s_axis_tvalid && (req_cmd == arsl_pkg::CMD_INSERT_VAR) && !req_full;
      end
      arsl_pkg::ST_SCAN: begin
        rd_addr = ptr_inc;
      end
      arsl_pkg::ST_EMIT: begin
        rd_addr = ptr_inc;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // region memories: one write and one read per cycle each
  always_ff @(posedge clk) begin
    if (wr_func) begin
      func_mem[func_count[IDX_W-1:0]] <= {req_size, req_addr};
    end
    if (wr_var) begin
      var_mem[var_count[IDX_W-1:0]] <= {req_size, req_addr};
    end
    func_rd <= func_mem[rd_addr];
    var_rd  <= var_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= arsl_pkg::ST_IDLE;
      func_count    <= '0;
      var_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_func) begin
        func_count <= func_count + 1'b1;
      end
      if (wr_var) begin
        var_count <= var_count + 1'b1;
      end
      if (state == arsl_pkg::ST_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // request capture, scan pointer and result
  always_ff @(posedge clk) begin
    if (req_accept) begin
      scan_var  <= req_is_var;
      scan_addr <= req_addr;
      scan_size <= req_size;
      scan_ptr  <= '0;
      if (req_lookup) begin
        res_status <= arsl_pkg::STATUS_MISS;
        res_index  <= '0;
      end else if (req_full) begin
        res_status <= arsl_pkg::STATUS_FULL;
        res_index  <= '0;
      end else begin
        res_status <= arsl_pkg::STATUS_OK;
        res_index  <= cnt_wide[arsl_pkg::INDEX_W-1:0];
      end
    end else if (state == arsl_pkg::ST_SCAN) begin
      scan_ptr <= ptr_inc;
      if (scan_hit) begin
        res_status <= arsl_pkg::STATUS_OK;
        res_index  <= ptr_wide[arsl_pkg::INDEX_W-1:0];
      end
    end
    if (state == arsl_pkg::ST_EMIT && out_free) begin
      m_axis_tdata <= {res_index, res_status};
    end
  end

  // checks
  a_func_count_bound: assert property (@(posedge clk) disable iff (rst)
    func_count <= CNT_W'(TABLE_DEPTH))
    else $error("function count beyond table depth");

  a_var_count_bound: assert property (@(posedge clk) disable iff (rst)
    var_count <= CNT_W'(TABLE_DEPTH))
    else $error("variable count beyond table depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> !s_axis_tready)
    else $error("request accepted while previous one in progress");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == arsl_pkg::ST_SCAN |-> CNT_W'(scan_ptr) < sel_count)
    else $error("scan pointer past valid entries");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == arsl_pkg::ST_EMIT)
    else $error("result raised outside emit state");

endmodule
